// ===== rtl/lbvs_pkg.sv =====
// Package for the linear blend vertex skinning core.
// Holds the operation codes, sequencer types and fixed datapath widths.
// No dependencies.
package lbvs_pkg;

   localparam int MAX_BONES_DEF    = 64;
   localparam int INFLUENCES_DEF   = 4;
   localparam int ENTRIES_PER_BONE = 12;
   localparam int ADDR_WIDE_W      = 12;
   localparam int COORD_W          = 32;
   localparam int WEIGHT_W         = 16;
   localparam int MUL_W            = 33;
   localparam int PROD_W           = 2 * MUL_W;
   localparam int DOT_W            = PROD_W - 16;
   localparam int ACC_W            = 56;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_SLOT  = 2'd1,
      OP_XFORM = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROW,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      SP_ADDR0,
      SP_MUL0,
      SP_MUL1,
      SP_MUL2,
      SP_ADD3,
      SP_WLO,
      SP_WHI,
      SP_ACC
   } step_type;

endpackage

// ===== rtl/lbvs_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module lbvs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lbvs_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on lbvs_pkg for the operand width.
module lbvs_mul (
   input  logic                                 clock,
   input  logic signed [lbvs_pkg::MUL_W-1:0]    mul_a,
   input  logic signed [lbvs_pkg::MUL_W-1:0]    mul_b,
   output logic signed [lbvs_pkg::PROD_W-1:0]   product
);

   logic signed [lbvs_pkg::PROD_W-1:0] product_ff;

   always_ff @(posedge clock) begin
      product_ff <= mul_a * mul_b;
   end

   assign product = product_ff;

endmodule

// ===== rtl/linear_blend_vertex_skinning_core.sv =====
// Top level of the linear blend vertex skinning core: sequencer and accumulators.
// Depends on lbvs_pkg, lbvs_ram (bone matrix store) and lbvs_mul (shared multiplier).
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    opcode, bone, entry, entry_value, slot, weight, pos
//   rsp      out        rsp_valid/stall    out_x, out_y, out_z, saturated
//
// A load or slot transaction leaves the sequencer idle. A vertex transaction takes each
// matrix row through steps ADDR0, MUL0, MUL1, MUL2, ADD3, WLO, WHI and ACC on the one
// shared multiplier and skips a slot whose bone is out of range. The matrix store has
// no reset; the slot table clears on reset. A finished result waits in the output
// register while the next transaction is taken; the sequencer holds in its last step
// only while the earlier result is still in the output register and rsp_stall is high.
module linear_blend_vertex_skinning_core #(
   parameter int MAX_BONES  = lbvs_pkg::MAX_BONES_DEF,
   parameter int INFLUENCES = lbvs_pkg::INFLUENCES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_opcode,
   input  logic [5:0]          req_bone,
   input  logic [3:0]          req_entry,
   input  logic signed [31:0]  req_entry_value,
   input  logic [1:0]          req_slot,
   input  logic [15:0]         req_weight,
   input  logic signed [31:0]  req_pos_x,
   input  logic signed [31:0]  req_pos_y,
   input  logic signed [31:0]  req_pos_z,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_out_x,
   output logic signed [31:0]  rsp_out_y,
   output logic signed [31:0]  rsp_out_z,
   output logic                rsp_saturated
);

   localparam int DEPTH   = MAX_BONES * lbvs_pkg::ENTRIES_PER_BONE;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int SLOT_IW = (INFLUENCES > 1) ? $clog2(INFLUENCES) : 1;
   localparam int AW      = lbvs_pkg::ADDR_WIDE_W;
   localparam int DW      = lbvs_pkg::DOT_W;
   localparam int CW      = lbvs_pkg::ACC_W;
   localparam int MW      = lbvs_pkg::MUL_W;

   localparam logic signed [CW-1:0] SAT_MAX = {{(CW-31){1'b0}}, {31{1'b1}}};
   localparam logic signed [CW-1:0] SAT_MIN = {{(CW-31){1'b1}}, {31{1'b0}}};

   lbvs_pkg::state_type state_ff, state_in;
   lbvs_pkg::step_type  step_ff, step_in;
   logic [1:0]          row_ff, row_in;
   logic [SLOT_IW-1:0]  slot_ff, slot_in;
   logic signed [31:0]  pos_ff [3];
   logic signed [31:0]  pos_in [3];
   logic signed [DW-1:0] dot_ff, dot_in;
   logic signed [CW-1:0] acc_ff [3];
   logic signed [CW-1:0] acc_in [3];
   logic [5:0]           slot_bone_ff [INFLUENCES];
   logic [5:0]           slot_bone_in [INFLUENCES];
   logic [15:0]          slot_weight_ff [INFLUENCES];
   logic [15:0]          slot_weight_in [INFLUENCES];
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]   out_ff [3];
   logic signed [31:0]   out_in [3];
   logic                 sat_ff, sat_in;

   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_waddr;
   logic [ADDR_W-1:0]    ram_raddr;
   logic [31:0]          ram_rdata;
   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [lbvs_pkg::PROD_W-1:0] product;

   logic [5:0]           cur_bone;
   logic [15:0]          cur_weight;
   logic                 bone_ok;
   logic                 slot_last;
   logic [1:0]           col;
   logic [AW-1:0]        rd_wide;
   logic [AW-1:0]        wr_wide;
   logic                 load_ok;
   logic                 set_ok;
   logic signed [DW-1:0] prod_shr;
   logic                 sat_any;
   logic signed [31:0]   sat_val [3];

   assign cur_bone   = slot_bone_ff[slot_ff];
   assign cur_weight = slot_weight_ff[slot_ff];
   assign bone_ok    = int'(cur_bone) < MAX_BONES;
   assign slot_last  = (slot_ff == SLOT_IW'(INFLUENCES - 1));
   assign load_ok    = (int'(req_entry) < lbvs_pkg::ENTRIES_PER_BONE)
                       && (int'(req_bone) < MAX_BONES);
   assign set_ok     = int'(req_slot) < INFLUENCES;
   assign prod_shr   = product[lbvs_pkg::PROD_W-1:16];

   always_comb begin
      case (step_ff)
         lbvs_pkg::SP_ADDR0: col = 2'd0;
         lbvs_pkg::SP_MUL0:  col = 2'd1;
         lbvs_pkg::SP_MUL1:  col = 2'd2;
         default:            col = 2'd3;
      endcase
   end

   assign rd_wide   = AW'(cur_bone) * AW'(lbvs_pkg::ENTRIES_PER_BONE) + AW'({row_ff, col});
   assign wr_wide   = AW'(req_bone) * AW'(lbvs_pkg::ENTRIES_PER_BONE) + AW'(req_entry);
   assign ram_raddr = ADDR_W'(rd_wide);
   assign ram_waddr = ADDR_W'(wr_wide);

   lbvs_ram #(
      .WIDTH(32),
      .DEPTH(DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(req_entry_value),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   lbvs_mul u_mul (
      .clock  (clock),
      .mul_a  (mul_a),
      .mul_b  (mul_b),
      .product(product)
   );

   always_comb begin
      sat_any = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (acc_ff[i] > SAT_MAX) begin
            sat_val[i] = 32'sh7FFF_FFFF;
            sat_any    = 1'b1;
         end else if (acc_ff[i] < SAT_MIN) begin
            sat_val[i] = 32'sh8000_0000;
            sat_any    = 1'b1;
         end else begin
            sat_val[i] = acc_ff[i][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lbvs_pkg::ST_IDLE;
         step_ff      <= lbvs_pkg::SP_ADDR0;
         row_ff       <= '0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < INFLUENCES; i++) begin
            slot_bone_ff[i]   <= '0;
            slot_weight_ff[i] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         step_ff        <= step_in;
         row_ff         <= row_in;
         slot_ff        <= slot_in;
         rsp_valid_ff   <= rsp_valid_in;
         slot_bone_ff   <= slot_bone_in;
         slot_weight_ff <= slot_weight_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      dot_ff <= dot_in;
      acc_ff <= acc_in;
      out_ff <= out_in;
      sat_ff <= sat_in;
   end

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      row_in         = row_ff;
      slot_in        = slot_ff;
      pos_in         = pos_ff;
      dot_in         = dot_ff;
      acc_in         = acc_ff;
      slot_bone_in   = slot_bone_ff;
      slot_weight_in = slot_weight_ff;
      out_in         = out_ff;
      sat_in         = sat_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      ram_we         = 1'b0;
      mul_a          = {ram_rdata[31], ram_rdata};
      mul_b          = {pos_ff[0][31], pos_ff[0]};

      case (state_ff)
         lbvs_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_opcode)
                  lbvs_pkg::OP_LOAD: begin
                     ram_we = load_ok;
                  end
                  lbvs_pkg::OP_SLOT: begin
                     if (set_ok) begin
                        slot_bone_in[SLOT_IW'(req_slot)]   = req_bone;
                        slot_weight_in[SLOT_IW'(req_slot)] = req_weight;
                     end
                  end
                  lbvs_pkg::OP_XFORM: begin
                     pos_in[0] = req_pos_x;
                     pos_in[1] = req_pos_y;
                     pos_in[2] = req_pos_z;
                     for (int i = 0; i < 3; i++) begin
                        acc_in[i] = '0;
                     end
                     step_in  = lbvs_pkg::SP_ADDR0;
                     row_in   = '0;
                     slot_in  = '0;
                     state_in = lbvs_pkg::ST_ROW;
                  end
                  default: begin
                  end
               endcase
            end
         end

         lbvs_pkg::ST_ROW: begin
            case (step_ff)
               lbvs_pkg::SP_ADDR0: begin
                  dot_in = '0;
                  if (bone_ok) begin
                     step_in = lbvs_pkg::SP_MUL0;
                  end else if (slot_last) begin
                     state_in = lbvs_pkg::ST_FINISH;
                  end else begin
                     slot_in = slot_ff + 1'b1;
                     row_in  = '0;
                  end
               end
               lbvs_pkg::SP_MUL0: begin
                  mul_b   = {pos_ff[0][31], pos_ff[0]};
                  step_in = lbvs_pkg::SP_MUL1;
               end
               lbvs_pkg::SP_MUL1: begin
                  mul_b   = {pos_ff[1][31], pos_ff[1]};
                  dot_in  = dot_ff + prod_shr;
                  step_in = lbvs_pkg::SP_MUL2;
               end
               lbvs_pkg::SP_MUL2: begin
                  mul_b   = {pos_ff[2][31], pos_ff[2]};
                  dot_in  = dot_ff + prod_shr;
                  step_in = lbvs_pkg::SP_ADD3;
               end
               lbvs_pkg::SP_ADD3: begin
                  dot_in  = dot_ff + prod_shr
                            + {{(DW-32){ram_rdata[31]}}, ram_rdata};
                  step_in = lbvs_pkg::SP_WLO;
               end
               lbvs_pkg::SP_WLO: begin
                  mul_a   = {1'b0, dot_ff[31:0]};
                  mul_b   = {{(MW-16){1'b0}}, cur_weight};
                  step_in = lbvs_pkg::SP_WHI;
               end
               lbvs_pkg::SP_WHI: begin
                  mul_a   = {{(MW-(DW-32)){dot_ff[DW-1]}}, dot_ff[DW-1:32]};
                  mul_b   = {{(MW-16){1'b0}}, cur_weight};
                  acc_in[row_ff] = acc_ff[row_ff]
                                   + {{(CW-DW){1'b0}}, product[lbvs_pkg::PROD_W-1:16]};
                  step_in = lbvs_pkg::SP_ACC;
               end
               default: begin
                  acc_in[row_ff] = acc_ff[row_ff] + {product[CW-17:0], 16'b0};
                  step_in        = lbvs_pkg::SP_ADDR0;
                  if (row_ff != 2'd2) begin
                     row_in = row_ff + 1'b1;
                  end else if (slot_last) begin
                     state_in = lbvs_pkg::ST_FINISH;
                  end else begin
                     row_in  = '0;
                     slot_in = slot_ff + 1'b1;
                  end
               end
            endcase
         end

         lbvs_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_in       = sat_val;
               sat_in       = sat_any;
               rsp_valid_in = 1'b1;
               state_in     = lbvs_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = lbvs_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_stall     = (state_ff != lbvs_pkg::ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_x     = out_ff[0];
   assign rsp_out_y     = out_ff[1];
   assign rsp_out_z     = out_ff[2];
   assign rsp_saturated = sat_ff;

endmodule

// ===== bench/lbvs_bench_pkg.sv =====
// Transaction types and scoreboard for the linear blend vertex skinning bench.
// Depends on lbvs_pkg for the operation codes and the store dimensions.
package lbvs_bench_pkg;
   import lbvs_pkg::*;

   typedef struct {
      opcode_type         opcode;
      logic [5:0]         bone;
      logic [3:0]         entry;
      logic signed [31:0] entry_value;
      logic [1:0]         slot;
      logic [15:0]        weight;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } skin_req_t;

   typedef struct {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic               saturated;
   } skin_rsp_t;

   localparam longint COORD_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam longint COORD_MIN = -64'sh0000_0000_8000_0000;

   class skinning_scoreboard;
      bit signed [31:0] bone_rows [MAX_BONES_DEF * ENTRIES_PER_BONE];
      bit [5:0]         slot_bone [INFLUENCES_DEF];
      bit [15:0]        slot_weight [INFLUENCES_DEF];
      skin_rsp_t        pending_vertices [$];
      int               failures;

      function int pending();
         return pending_vertices.size();
      endfunction

      function void note_request(skin_req_t r);
         skin_rsp_t res;
         longint    pos [3];
         longint    acc [3];
         longint    dotp;
         longint    hi;
         longint    lo;
         longint    w;
         int        base;
         bit        clamped;
         case (r.opcode)
            OP_LOAD: begin
               if (r.entry < ENTRIES_PER_BONE && r.bone < MAX_BONES_DEF)
                  bone_rows[r.bone * ENTRIES_PER_BONE + r.entry] = r.entry_value;
            end
            OP_SLOT: begin
               if (r.slot < INFLUENCES_DEF) begin
                  slot_bone[r.slot] = r.bone;
                  slot_weight[r.slot] = r.weight;
               end
            end
            OP_XFORM: begin
               pos[0] = r.pos_x;
               pos[1] = r.pos_y;
               pos[2] = r.pos_z;
               acc = '{0, 0, 0};
               clamped = 1'b0;
               for (int s = 0; s < INFLUENCES_DEF; s++) begin
                  if (slot_bone[s] >= MAX_BONES_DEF)
                     continue;
                  w = longint'(slot_weight[s]);
                  for (int row = 0; row < 3; row++) begin
                     base = slot_bone[s] * ENTRIES_PER_BONE + row * 4;
                     dotp = longint'(bone_rows[base + 3]);
                     for (int c = 0; c < 3; c++)
                        dotp += (longint'(bone_rows[base + c]) * pos[c]) >>> 16;
                     // Split the row sum so the weight product cannot overflow 64 bits.
                     hi = dotp >>> 16;
                     lo = dotp - (hi <<< 16);
                     acc[row] += hi * w + ((lo * w) >>> 16);
                  end
               end
               for (int row = 0; row < 3; row++) begin
                  if (acc[row] > COORD_MAX) begin
                     acc[row] = COORD_MAX;
                     clamped = 1'b1;
                  end
                  if (acc[row] < COORD_MIN) begin
                     acc[row] = COORD_MIN;
                     clamped = 1'b1;
                  end
               end
               res.out_x = acc[0][31:0];
               res.out_y = acc[1][31:0];
               res.out_z = acc[2][31:0];
               res.saturated = clamped;
               pending_vertices.push_back(res);
            end
            default: ;
         endcase
      endfunction

      function void check_result(skin_rsp_t got);
         skin_rsp_t want;
         if (pending_vertices.size() == 0) begin
            $error("rsp transaction with no vertex outstanding: x=%0d y=%0d z=%0d",
                   got.out_x, got.out_y, got.out_z);
            failures++;
            return;
         end
         want = pending_vertices.pop_front();
         if (got.out_x !== want.out_x) begin
            $error("out_x mismatch: expected %0d, got %0d", want.out_x, got.out_x);
            failures++;
         end
         if (got.out_y !== want.out_y) begin
            $error("out_y mismatch: expected %0d, got %0d", want.out_y, got.out_y);
            failures++;
         end
         if (got.out_z !== want.out_z) begin
            $error("out_z mismatch: expected %0d, got %0d", want.out_z, got.out_z);
            failures++;
         end
         if (got.saturated !== want.saturated) begin
            $error("saturated mismatch: expected %0b, got %0b", want.saturated, got.saturated);
            failures++;
         end
      endfunction
   endclass

endpackage

// ===== bench/tb.sv =====
// Top-level bench for linear_blend_vertex_skinning_core: drives matrix loads, slot sets
// and vertex transactions under random idling and checks every skinned vertex.
// Depends on lbvs_pkg and lbvs_bench_pkg.
module tb;
   import lbvs_pkg::*;
   import lbvs_bench_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 200;
   localparam int LONG_HOLD    = 600;
   localparam int PHASE_ITEMS  = 610;

   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_stall;
   logic [1:0]         req_opcode      = OP_NONE;
   logic [5:0]         req_bone        = '0;
   logic [3:0]         req_entry       = '0;
   logic signed [31:0] req_entry_value = '0;
   logic [1:0]         req_slot        = '0;
   logic [15:0]        req_weight      = '0;
   logic signed [31:0] req_pos_x       = '0;
   logic signed [31:0] req_pos_y       = '0;
   logic signed [31:0] req_pos_z       = '0;
   logic               rsp_valid;
   logic               rsp_stall       = 1'b0;
   logic signed [31:0] rsp_out_x;
   logic signed [31:0] rsp_out_y;
   logic signed [31:0] rsp_out_z;
   logic               rsp_saturated;

   skinning_scoreboard board = new();

   bit       entry_loaded [MAX_BONES_DEF][ENTRIES_PER_BONE];
   bit [5:0] slot_bone_now [INFLUENCES_DEF];
   int       send_idle_pct = 14;
   int       recv_idle_pct = 46;
   int       counted_items = 0;
   int       hold_requests = 0;
   int       holds_served  = 0;
   int       hold_left     = 0;
   int       cycle_count   = 0;

   always #4 clock = ~clock;

   linear_blend_vertex_skinning_core dut (.*);

   function automatic logic [31:0] matrix_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom_range(0, 32'h2_0000) - 32'h1_0000;
         4, 5: return $urandom_range(0, 32'h20_0000) - 32'h10_0000;
         6: return 32'h0;
         7: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pos_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return $urandom_range(0, 32'h200_0000) - 32'h100_0000;
         5, 6: return $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
         7: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] weight_value(int k);
      case ($urandom_range(0, 5))
         0, 1: return 16'($urandom_range(0, 65535));
         2, 3: return 16'($urandom_range(0, 65535 / k));
         4: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: return 16'(65535 / k);
      endcase
   endfunction

   function automatic logic [5:0] pick_bone();
      return ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, 7))
                                         : 6'($urandom_range(0, 63));
   endfunction

   function automatic skin_req_t random_item(opcode_type op);
      skin_req_t it;
      it.opcode      = op;
      it.bone        = 6'($urandom_range(0, 63));
      it.entry       = 4'($urandom_range(0, 15));
      it.entry_value = $urandom;
      it.slot        = 2'($urandom_range(0, 3));
      it.weight      = 16'($urandom_range(0, 65535));
      it.pos_x       = $urandom;
      it.pos_y       = $urandom;
      it.pos_z       = $urandom;
      return it;
   endfunction

   task automatic send(input skin_req_t it);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= it.opcode;
      req_bone        <= it.bone;
      req_entry       <= it.entry;
      req_entry_value <= it.entry_value;
      req_slot        <= it.slot;
      req_weight      <= it.weight;
      req_pos_x       <= it.pos_x;
      req_pos_y       <= it.pos_y;
      req_pos_z       <= it.pos_z;
      do
         @(posedge clock);
      while (req_stall);
      board.note_request(it);
      if (it.opcode == OP_LOAD && it.entry < ENTRIES_PER_BONE)
         entry_loaded[it.bone][it.entry] = 1'b1;
      if (it.opcode == OP_SLOT)
         slot_bone_now[it.slot] = it.bone;
      if (!(it.opcode == OP_NONE || (it.opcode == OP_LOAD && it.entry >= ENTRIES_PER_BONE)))
         counted_items++;
   endtask

   task automatic load_entry(input logic [5:0] b, input logic [3:0] e,
                             input logic [31:0] v);
      skin_req_t it;
      it = random_item(OP_LOAD);
      it.bone = b;
      it.entry = e;
      it.entry_value = v;
      send(it);
   endtask

   // A vertex must never read a matrix entry that was not written.
   task automatic ensure_bone(input logic [5:0] b);
      for (int e = 0; e < ENTRIES_PER_BONE; e++) begin
         if (!entry_loaded[b][e])
            load_entry(b, 4'(e), matrix_value());
      end
   endtask

   task automatic set_slot(input logic [1:0] s, input logic [5:0] b, input logic [15:0] w);
      skin_req_t it;
      ensure_bone(b);
      it = random_item(OP_SLOT);
      it.slot = s;
      it.bone = b;
      it.weight = w;
      send(it);
   endtask

   task automatic transform(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
      skin_req_t it;
      for (int s = 0; s < INFLUENCES_DEF; s++)
         ensure_bone(slot_bone_now[s]);
      it = random_item(OP_XFORM);
      it.pos_x = x;
      it.pos_y = y;
      it.pos_z = z;
      send(it);
   endtask

   task automatic run_traffic(input int target);
      int first;
      int k;
      first = counted_items;
      while (counted_items - first < target) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
               k = $urandom_range(1, INFLUENCES_DEF);
               for (int i = 0; i < k; i++)
                  set_slot(2'($urandom_range(0, 3)), pick_bone(), weight_value(k));
               repeat ($urandom_range(1, 6))
                  transform(pos_value(), pos_value(), pos_value());
            end
            10, 11, 12: begin
               k = $urandom_range(0, INFLUENCES_DEF - 1);
               repeat ($urandom_range(1, 4))
                  load_entry(slot_bone_now[k], 4'($urandom_range(0, 11)), matrix_value());
               repeat ($urandom_range(1, 3))
                  transform(pos_value(), pos_value(), pos_value());
            end
            13, 14, 15: begin
               case ($urandom_range(0, 3))
                  0: send(random_item(OP_NONE));
                  1: load_entry(6'($urandom_range(0, 63)), 4'($urandom_range(12, 15)),
                                $urandom);
                  2: load_entry(pick_bone(), 4'($urandom_range(0, 11)), matrix_value());
                  default: send(random_item(OP_SLOT));
               endcase
            end
            default: begin
               repeat ($urandom_range(1, 3))
                  transform(pos_value(), pos_value(), pos_value());
            end
         endcase
      end
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         rsp_stall <= 1'b1;
         hold_left <= LONG_HOLD;
         holds_served <= hold_requests;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result('{rsp_out_x, rsp_out_y, rsp_out_z, rsp_saturated});
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      logic [31:0] corner [ENTRIES_PER_BONE];
      corner = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                 32'h0000_0000, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'hFFFF_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int e = 0; e < ENTRIES_PER_BONE; e++)
         load_entry(6'd0, 4'(e), corner[e]);
      // All weights are still zero after reset, so this vertex collapses to the origin.
      transform(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
      set_slot(2'd0, 6'd0, 16'hFFFF);
      transform(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      transform(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      transform(32'h0, 32'h0, 32'h0);
      set_slot(2'd3, 6'd0, 16'h8000);
      transform(32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678);
      // Loads to entries past the third row and the unused opcode must leave state alone.
      load_entry(6'd0, 4'd12, 32'h5A5A_5A5A);
      load_entry(6'd63, 4'd15, 32'hA5A5_A5A5);
      send(random_item(OP_NONE));
      transform(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);

      run_traffic(PHASE_ITEMS);
      send_idle_pct = 46;
      recv_idle_pct = 14;
      run_traffic(PHASE_ITEMS);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests <= hold_requests + 1;
      run_traffic(PHASE_ITEMS);
      req_valid <= 1'b0;

      while (board.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.failures == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/lbvs_pkg.sv
rtl/lbvs_ram.sv
rtl/lbvs_mul.sv
rtl/linear_blend_vertex_skinning_core.sv
bench/lbvs_bench_pkg.sv
bench/tb.sv
